[src/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Shared property wrappers for the concurrent checks in the RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

[src/rpd_pkg.sv]
// ---------------------------------------------------------------------------
// rpd_pkg
// Widths, codes and helpers shared by the permutation draw unit.
// ---------------------------------------------------------------------------
`default_nettype none

package rpd_pkg;

  localparam int MAX_ITEMS = 64;
  localparam int IDX_W     = $clog2(MAX_ITEMS);
  localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
  localparam int T_W       = IDX_W + 1;

  localparam int DECK_W    = 7;
  localparam int WORD_W    = 31;
  localparam int ITEM_W    = 6;

  localparam int DIV_STEPS = WORD_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  localparam logic [DECK_W-1:0] DECK_RESET = DECK_W'(52);

  localparam logic KIND_RESTART = 1'b0;
  localparam logic KIND_DRAW    = 1'b1;

  // Pool access request from the sequencer.
  typedef struct packed {
    logic [IDX_W-1:0] rd_addr_a;
    logic [IDX_W-1:0] rd_addr_b;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [IDX_W-1:0] wr_data;
    logic             clear;
  } pool_req_t;

  // Deck sizes above the pool depth saturate to the pool depth.
  function automatic logic [CNT_W-1:0] eff_size(input logic [DECK_W-1:0] size);
    if (int'(size) > MAX_ITEMS) begin
      return CNT_W'(MAX_ITEMS);
    end
    return CNT_W'(size);
  endfunction

  localparam logic [CNT_W-1:0] REMAIN_RESET = eff_size(DECK_RESET);

endpackage

`default_nettype wire

[src/random_permutation_draw_unit.sv]
// A draw passes from the start transfer through the bit-serial remainder unit
// (one bit of the random word per cycle), a pool read and a pool write to the
// result strobe. A restart gives no result; a draw on an empty pool gives its
// exhausted result in the cycle after the transfer.
// Busy is low again in the cycle the result is shown; results cannot be stalled.
// Synchronous active-low reset: deck size 52, pool in identity order, 52 live.
// ---------------------------------------------------------------------------
// random_permutation_draw_unit
// Fisher-Yates draw engine: picks a random live pool entry, fills the hole
// with the last live entry and shrinks the pool by one.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module random_permutation_draw_unit (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic                        in_kind,
  input  wire logic [rpd_pkg::WORD_W-1:0]  in_random_word,
  output logic                             out_valid,
  output logic [rpd_pkg::ITEM_W-1:0]       out_item,
  output logic                             out_last_item,
  output logic                             out_exhausted,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [rpd_pkg::DECK_W-1:0]  cfg_deck_size
);
  import rpd_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_MOD   = 4'b0010,
    S_READ  = 4'b0100,
    S_WRITE = 4'b1000
  } state_t;

  state_t              state_r, state_nxt;
  logic [DECK_W-1:0]   deck_size_r;
  logic [CNT_W-1:0]    remaining_r, remaining_nxt;
  logic [IDX_W-1:0]    pos_r, pos_nxt;
  logic [IDX_W-1:0]    lastpos_r, lastpos_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [ITEM_W-1:0]   out_item_r, out_item_nxt;
  logic                out_last_r, out_last_nxt;
  logic                out_exh_r, out_exh_nxt;
  logic                mod_start;
  logic                mod_done;
  logic [IDX_W-1:0]    mod_rem;
  pool_req_t           pool_req;
  logic [IDX_W-1:0]    pool_rd_a;
  logic [IDX_W-1:0]    pool_rd_b;

  rpd_mod_unit u_mod (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (mod_start),
    .dividend  (in_random_word),
    .divisor   (remaining_r),
    .done      (mod_done),
    .remainder (mod_rem)
  );

  rpd_pool u_pool (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (pool_req),
    .rd_data_a (pool_rd_a),
    .rd_data_b (pool_rd_b)
  );

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;

  always_comb begin
    state_nxt          = state_r;
    remaining_nxt      = remaining_r;
    pos_nxt            = pos_r;
    lastpos_nxt        = lastpos_r;
    out_valid_nxt      = 1'b0;
    out_item_nxt       = '0;
    out_last_nxt       = 1'b0;
    out_exh_nxt        = 1'b0;
    mod_start          = 1'b0;
    pool_req.rd_addr_a = pos_r;
    pool_req.rd_addr_b = lastpos_r;
    pool_req.wr_en     = 1'b0;
    pool_req.wr_addr   = pos_r;
    pool_req.wr_data   = pool_rd_b;
    pool_req.clear     = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          if (in_kind == KIND_RESTART) begin
            pool_req.clear = 1'b1;
            remaining_nxt  = eff_size(deck_size_r);
          end else if (remaining_r == '0) begin
            out_valid_nxt = 1'b1;
            out_exh_nxt   = 1'b1;
          end else begin
            mod_start   = 1'b1;
            lastpos_nxt = IDX_W'(remaining_r - CNT_W'(1));
            state_nxt   = S_MOD;
          end
        end
      end
      S_MOD: begin
        if (mod_done) begin
          pos_nxt   = mod_rem;
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        // Read data for the drawn slot and the last live slot lands next cycle.
        state_nxt = S_WRITE;
      end
      S_WRITE: begin
        pool_req.wr_en = 1'b1;
        out_valid_nxt  = 1'b1;
        out_item_nxt   = ITEM_W'(pool_rd_a);
        out_last_nxt   = (remaining_r == CNT_W'(1));
        remaining_nxt  = remaining_r - CNT_W'(1);
        state_nxt      = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      deck_size_r <= DECK_RESET;
      remaining_r <= REMAIN_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      remaining_r <= remaining_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        deck_size_r <= cfg_deck_size;
      end
    end
  end

  always_ff @(posedge clk) begin
    pos_r      <= pos_nxt;
    lastpos_r  <= lastpos_nxt;
    out_item_r <= out_item_nxt;
    out_last_r <= out_last_nxt;
    out_exh_r  <= out_exh_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_item      = out_item_r;
  assign out_last_item = out_last_r;
  assign out_exhausted = out_exh_r;

  `ASSERT_IMPL(a_remaining_bound, clk, rst_n, 1'b1, int'(remaining_r) <= MAX_ITEMS, "pool count above depth")
  `ASSERT_IMPL(a_pos_in_pool, clk, rst_n, state_r == S_READ, CNT_W'(pos_r) < remaining_r, "draw position outside live pool")
  `ASSERT_NEXT(a_draw_shrinks, clk, rst_n, state_r == S_WRITE, remaining_r == $past(remaining_r) - CNT_W'(1), "draw did not shrink pool")
  `ASSERT_IMPL(a_draw_strobe, clk, rst_n, out_valid_r && !out_exh_r, $past(state_r == S_WRITE), "draw result without pool write")

endmodule

`default_nettype wire

[src/rpd_mod_unit.sv]
// ---------------------------------------------------------------------------
// rpd_mod_unit
// Bit-serial restoring remainder of the random word by the live pool count.
// ---------------------------------------------------------------------------
`default_nettype none

module rpd_mod_unit (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  input  wire logic [rpd_pkg::WORD_W-1:0] dividend,
  input  wire logic [rpd_pkg::CNT_W-1:0]  divisor,
  output logic                          done,
  output logic [rpd_pkg::IDX_W-1:0]     remainder
);
  import rpd_pkg::*;

  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  logic [STEP_W-1:0]   cnt_r, cnt_nxt;
  logic [WORD_W-1:0]   dvd_r, dvd_nxt;
  logic [CNT_W-1:0]    dsr_r, dsr_nxt;
  logic [IDX_W-1:0]    rem_r, rem_nxt;
  logic [T_W-1:0]      trial;
  logic [T_W-1:0]      dsr_ext;

  // One quotient bit per cycle: the remainder stays below the divisor, so it
  // always fits the pool index width.
  always_comb begin
    trial    = {rem_r, dvd_r[WORD_W-1]};
    dsr_ext  = T_W'(dsr_r);
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    dsr_nxt  = dsr_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      dvd_nxt  = dividend;
      dsr_nxt  = divisor;
      rem_nxt  = '0;
    end else if (busy_r) begin
      dvd_nxt = {dvd_r[WORD_W-2:0], 1'b0};
      if (trial >= dsr_ext) begin
        rem_nxt = IDX_W'(trial - dsr_ext);
      end else begin
        rem_nxt = IDX_W'(trial);
      end
      cnt_nxt = cnt_r + STEP_W'(1);
      if (cnt_r == STEP_W'(DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    dsr_r <= dsr_nxt;
    rem_r <= rem_nxt;
  end

  assign done      = done_r;
  assign remainder = rem_r;

endmodule

`default_nettype wire

[src/rpd_pool.sv]
// ---------------------------------------------------------------------------
// rpd_pool
// Pool memory with per-entry valid bits; an unwritten entry reads as its index.
// ---------------------------------------------------------------------------
`default_nettype none

module rpd_pool (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire rpd_pkg::pool_req_t     req,
  output logic [rpd_pkg::IDX_W-1:0]   rd_data_a,
  output logic [rpd_pkg::IDX_W-1:0]   rd_data_b
);
  import rpd_pkg::*;

  logic [IDX_W-1:0]     mem [MAX_ITEMS];
  logic [MAX_ITEMS-1:0] vld_r;
  logic [IDX_W-1:0]     rd_a_r;
  logic [IDX_W-1:0]     rd_b_r;

  // Clearing the valid bits restores the identity order.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (req.clear) begin
      vld_r <= '0;
    end else if (req.wr_en) begin
      vld_r[req.wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    rd_a_r <= vld_r[req.rd_addr_a] ? mem[req.rd_addr_a] : req.rd_addr_a;
    rd_b_r <= vld_r[req.rd_addr_b] ? mem[req.rd_addr_b] : req.rd_addr_b;
  end

  assign rd_data_a = rd_a_r;
  assign rd_data_b = rd_b_r;

endmodule

`default_nettype wire

[test/random_permutation_draw_checker.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// random_permutation_draw_checker
// Watches the command, result and deck size channels of the draw unit. It
// keeps its own pool and live count, predicts every result and compares the
// results field by field in order.
// ---------------------------------------------------------------------------
module random_permutation_draw_checker (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic                        busy,
  input  wire logic                        in_kind,
  input  wire logic [rpd_pkg::WORD_W-1:0]  in_random_word,
  input  wire logic                        out_valid,
  input  wire logic [rpd_pkg::ITEM_W-1:0]  out_item,
  input  wire logic                        out_last_item,
  input  wire logic                        out_exhausted,
  input  wire logic                        cfg_valid,
  input  wire logic                        cfg_ready,
  input  wire logic [rpd_pkg::DECK_W-1:0]  cfg_deck_size,
  output int                               failures,
  output int                               pending
);
  import rpd_pkg::*;

  typedef struct packed {
    logic [ITEM_W-1:0] item;
    logic              last_item;
    logic              exhausted;
  } dealt_t;

  dealt_t             dealt_q[$];
  logic [ITEM_W-1:0]  pool_model [MAX_ITEMS];
  logic [CNT_W-1:0]   live_count;
  logic [DECK_W-1:0]  deck_reg;
  int                 errors = 0;

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    errors++;
  endtask

  // A restart puts the identity order back; sizes above the pool depth saturate.
  task automatic refill_pool();
    for (int k = 0; k < MAX_ITEMS; k++) begin
      pool_model[k] = ITEM_W'(k);
    end
    if (int'(deck_reg) > MAX_ITEMS) begin
      live_count = CNT_W'(MAX_ITEMS);
    end else begin
      live_count = CNT_W'(deck_reg);
    end
  endtask

  task automatic draw_from_pool(input logic [WORD_W-1:0] word);
    dealt_t d;
    int     slot;
    d = '0;
    if (live_count == 0) begin
      d.exhausted = 1'b1;
    end else begin
      slot = int'(word % WORD_W'(live_count));
      d.item = pool_model[slot];
      // The last live entry fills the hole left by the drawn one.
      pool_model[slot] = pool_model[live_count - 1];
      live_count = live_count - 1'b1;
      d.last_item = (live_count == 0);
    end
    dealt_q.push_back(d);
  endtask

  always @(posedge clk) begin
    dealt_t want;
    if (!rst_n) begin
      deck_reg = DECK_RESET;
      refill_pool();
      dealt_q.delete();
    end else begin
      if (out_valid) begin
        if (dealt_q.size() == 0) begin
          report_mismatch($sformatf("result item=%0d last=%0b exhausted=%0b with none expected",
                                    out_item, out_last_item, out_exhausted));
        end else begin
          want = dealt_q.pop_front();
          if (out_item !== want.item) begin
            report_mismatch($sformatf("item got %0d expected %0d", out_item, want.item));
          end
          if (out_last_item !== want.last_item) begin
            report_mismatch($sformatf("last_item got %0b expected %0b",
                                      out_last_item, want.last_item));
          end
          if (out_exhausted !== want.exhausted) begin
            report_mismatch($sformatf("exhausted got %0b expected %0b",
                                      out_exhausted, want.exhausted));
          end
        end
      end
      // A restart in the same cycle as a deck size write still sees the old size.
      if (start && !busy) begin
        if (in_kind == KIND_RESTART) begin
          refill_pool();
        end else begin
          draw_from_pool(in_random_word);
        end
      end
      if (cfg_valid && cfg_ready) begin
        deck_reg = cfg_deck_size;
      end
    end
    failures <= errors;
    pending  <= dealt_q.size();
  end

endmodule

[test/random_permutation_draw_unit_test.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// random_permutation_draw_unit_test
// Drives restarts and draws into the draw unit under a range of deck sizes,
// from empty and single-item decks to oversized ones, with random pauses on
// the command side. A checker beside the unit predicts and compares results.
// ---------------------------------------------------------------------------
module random_permutation_draw_unit_test;
  import rpd_pkg::*;

  localparam int ITEM_TARGET   = 1700;
  localparam int CALM_FROM     = 1500;
  localparam int SETTLE_CYCLES = 40;
  localparam int DRAIN_LIMIT   = 400;

  logic              clk            = 1'b0;
  logic              rst_n          = 1'b0;
  logic              start          = 1'b0;
  logic              in_kind        = KIND_RESTART;
  logic [WORD_W-1:0] in_random_word = '0;
  logic              cfg_valid      = 1'b0;
  logic [DECK_W-1:0] cfg_deck_size  = DECK_RESET;

  logic              busy;
  logic              out_valid;
  logic [ITEM_W-1:0] out_item;
  logic              out_last_item;
  logic              out_exhausted;
  logic              cfg_ready;

  int failures;
  int pending;
  int items_sent = 0;
  bit gaps_on    = 1'b1;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  random_permutation_draw_unit dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_kind        (in_kind),
    .in_random_word (in_random_word),
    .out_valid      (out_valid),
    .out_item       (out_item),
    .out_last_item  (out_last_item),
    .out_exhausted  (out_exhausted),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_deck_size  (cfg_deck_size)
  );

  random_permutation_draw_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_kind        (in_kind),
    .in_random_word (in_random_word),
    .out_valid      (out_valid),
    .out_item       (out_item),
    .out_last_item  (out_last_item),
    .out_exhausted  (out_exhausted),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_deck_size  (cfg_deck_size),
    .failures       (failures),
    .pending        (pending)
  );

  function automatic logic [WORD_W-1:0] rand_word();
    return WORD_W'($urandom());
  endfunction

  task automatic pause_sender(input int cycles);
    start          <= 1'b0;
    in_kind        <= logic'($urandom_range(0, 1));
    in_random_word <= rand_word();
    repeat (cycles) @(posedge clk);
  endtask

  // Returns at the edge where the command transfer happens, start still high.
  task automatic send_item(input logic kind, input logic [WORD_W-1:0] word);
    start          <= 1'b1;
    in_kind        <= kind;
    in_random_word <= word;
    do @(posedge clk); while (busy);
    items_sent++;
    if (gaps_on && items_sent < CALM_FROM && $urandom_range(0, 3) == 0) begin
      pause_sender($urandom_range(1, 7));
    end
  endtask

  // The extra cycles cover a restart still in flight after the last result.
  task automatic wait_idle();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_deck(input logic [DECK_W-1:0] size);
    cfg_valid     <= 1'b1;
    cfg_deck_size <= size;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [DECK_W-1:0] pick_deck();
    case ($urandom_range(0, 11))
      0:       return DECK_W'(0);
      1:       return DECK_W'(1);
      2:       return DECK_W'(2);
      3:       return DECK_W'(MAX_ITEMS);
      4:       return DECK_W'($urandom_range(MAX_ITEMS + 1, 127));
      default: return DECK_W'($urandom_range(2, MAX_ITEMS));
    endcase
  endfunction

  initial begin
    logic [DECK_W-1:0] size;
    int                live;
    int                waited;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset deck of 52 with the smallest and largest random word.
    send_item(KIND_DRAW, '0);
    send_item(KIND_DRAW, '1);

    // The new size waits for a restart, so the first draw comes from the old pool.
    wait_idle();
    write_deck(DECK_W'(1));
    send_item(KIND_DRAW, rand_word());
    send_item(KIND_RESTART, rand_word());
    send_item(KIND_DRAW, rand_word());
    send_item(KIND_DRAW, rand_word());

    wait_idle();
    write_deck(DECK_W'(0));
    send_item(KIND_RESTART, '0);
    send_item(KIND_DRAW, '1);

    wait_idle();
    write_deck('1);
    send_item(KIND_RESTART, '1);
    send_item(KIND_DRAW, '1);
    send_item(KIND_DRAW, '0);

    wait_idle();
    write_deck(DECK_W'(MAX_ITEMS));
    send_item(KIND_RESTART, rand_word());
    send_item(KIND_DRAW, '1);
    send_item(KIND_DRAW, '0);

    wait_idle();
    write_deck(DECK_W'(2));
    send_item(KIND_RESTART, rand_word());
    send_item(KIND_DRAW, rand_word());
    send_item(KIND_DRAW, rand_word());
    send_item(KIND_DRAW, rand_word());
    send_item(KIND_DRAW, '1);
    send_item(KIND_RESTART, rand_word());
    send_item(KIND_DRAW, '0);

    // Each phase waits for all results, sets a new size and deals.
    while (items_sent < ITEM_TARGET) begin
      wait_idle();
      size = pick_deck();
      write_deck(size);
      live    = (int'(size) > MAX_ITEMS) ? MAX_ITEMS : int'(size);
      gaps_on = ($urandom_range(0, 2) != 0);
      case ($urandom_range(0, 9))
        0: begin
          repeat ($urandom_range(1, 12)) begin
            send_item(logic'($urandom_range(0, 1)), rand_word());
          end
        end
        1: begin
          send_item(KIND_RESTART, rand_word());
          repeat ($urandom_range(0, live)) send_item(KIND_DRAW, rand_word());
          send_item(KIND_RESTART, rand_word());
          repeat (live + 1) send_item(KIND_DRAW, rand_word());
        end
        default: begin
          send_item(KIND_RESTART, rand_word());
          repeat (live + $urandom_range(0, 2)) send_item(KIND_DRAW, rand_word());
        end
      endcase
    end

    start  <= 1'b0;
    waited = 0;
    do begin
      @(posedge clk);
      waited++;
    end while (pending != 0 && waited < DRAIN_LIMIT);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending != 0) begin
      $display("%0d expected results never arrived", pending);
    end
    if (failures == 0 && pending == 0) begin
      $display("PASS random_permutation_draw_unit");
    end else begin
      $display("FAIL random_permutation_draw_unit");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("timeout");
    $display("FAIL random_permutation_draw_unit");
    $finish;
  end

endmodule

[filelist.f]
+incdir+src
src/rpd_pkg.sv
src/rpd_mod_unit.sv
src/rpd_pool.sv
src/random_permutation_draw_unit.sv
test/random_permutation_draw_checker.sv
test/random_permutation_draw_unit_test.sv
